// ----- src/least_squares_line_fit_top_assert.svh -----
// ----------------------------------------------------------------------------
// least squares line fit assertion macros
// concurrent check wrappers, removable by defining NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_TOP_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define LSLF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lslf assertion failed");

// next-cycle implication, disabled during reset
`define LSLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lslf assertion failed");

`else

`define LSLF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LSLF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/lslf_pkg.sv -----
// ----------------------------------------------------------------------------
// least squares line fit package
// fixed widths of coefficients, accumulators and results
// ----------------------------------------------------------------------------
package lslf_pkg;

    localparam int COEF_WIDTH = 24;
    localparam int COEF_FRAC  = 21;
    localparam int ACC_WIDTH  = 48;
    localparam int OUT_WIDTH  = 32;

    localparam longint COEF_MAX = 64'sd8388607;
    localparam longint COEF_MIN = -64'sd8388608;
    localparam longint OUT_MAX  = 64'sd2147483647;
    localparam longint OUT_MIN  = -64'sd2147483648;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [ACC_WIDTH-1:0]  acc_t;
    typedef logic signed [OUT_WIDTH-1:0]  out_value_t;

endpackage

// ----- src/least_squares_line_fit_top.sv -----
// ----------------------------------------------------------------------------
// least squares line fit
// straight-line fit over vectors of samples: slope and centre offset
// ----------------------------------------------------------------------------
// Fits a least-squares line to every vector of VECTOR_LENGTH samples, with
// element i placed at x = i - VECTOR_LENGTH/2. Samples (signed, the low
// SAMPLE_WIDTH bits of s_axis_tdata) are taken one per clock, and the block
// sustains one sample per cycle for as long as the result side keeps up,
// since each sample costs one multiply and one 48-bit accumulate per weight.
// After the last sample of a vector the slope (low 32 bits of m_axis_tdata)
// and the offset at the centre index (high 32 bits), both signed Q28.4 for
// integer samples, rounded and saturated, leave after passing through stage
// a, stage b, the sum stage and the output register. The weights live in two
// ROMs built at elaboration from VECTOR_LENGTH; there is no configuration
// and no start-up sweep. VECTOR_LENGTH must be even.
// ----------------------------------------------------------------------------
`include "least_squares_line_fit_top_assert.svh"

module least_squares_line_fit_top #(
    parameter int VECTOR_LENGTH = 64,
    parameter int SAMPLE_WIDTH  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // fields: sample [SAMPLE_WIDTH-1:0], zero-filled to whole bytes
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // fields: slope_value [31:0], offset_value [63:32]
    output logic [2*lslf_pkg::OUT_WIDTH-1:0]       m_axis_tdata
);

    import lslf_pkg::*;

    // ------------------------------------------------------------------------
    // elaboration-time weight tables
    // ------------------------------------------------------------------------
    localparam int PosWidth  = $clog2(VECTOR_LENGTH);
    localparam int ProdWidth = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int OutShift  = SAMPLE_WIDTH + 1;
    localparam longint Half  = VECTOR_LENGTH / 2;
    localparam logic [PosWidth-1:0] LastPos = PosWidth'(VECTOR_LENGTH - 1);

    // sum of positions over one vector
    function automatic longint calc_sum_x();
        longint acc;
        acc = 0;
        for (int i = 0; i < VECTOR_LENGTH; i++) begin
            acc += longint'(i) - Half;
        end
        return acc;
    endfunction

    // sum of squared positions over one vector
    function automatic longint calc_sum_x2();
        longint acc;
        longint x;
        acc = 0;
        for (int i = 0; i < VECTOR_LENGTH; i++) begin
            x = longint'(i) - Half;
            acc += x * x;
        end
        return acc;
    endfunction

    localparam longint SumX    = calc_sum_x();
    localparam longint SumX2   = calc_sum_x2();
    localparam longint DenRaw  = longint'(VECTOR_LENGTH) * SumX2 - SumX * SumX;
    localparam longint WeightDen = (DenRaw > 0) ? DenRaw : 64'sd1;
    localparam longint HalfDen = WeightDen / 2;

    // round to Q2.21, ties away from zero, saturate to the coefficient range
    function automatic coef_t quantize_weight(input longint num);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< COEF_FRAC) + HalfDen) / WeightDen;
        if (num < 0) begin
            q = -q;
        end
        if (q > COEF_MAX) begin
            q = COEF_MAX;
        end
        if (q < COEF_MIN) begin
            q = COEF_MIN;
        end
        return COEF_WIDTH'(q);
    endfunction

    function automatic coef_t slope_weight(input int idx);
        longint x;
        x = longint'(idx) - Half;
        return quantize_weight(longint'(VECTOR_LENGTH) * x - SumX);
    endfunction

    function automatic coef_t offset_weight(input int idx);
        longint x;
        x = longint'(idx) - Half;
        return quantize_weight(SumX2 - SumX * x);
    endfunction

    // coefficient roms, read through a register at the input stage
    coef_t slope_rom  [VECTOR_LENGTH];
    coef_t offset_rom [VECTOR_LENGTH];

    for (genvar g = 0; g < VECTOR_LENGTH; g++) begin : g_rom
        assign slope_rom[g]  = slope_weight(g);
        assign offset_rom[g] = offset_weight(g);
    end

    // ------------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------------
    // element position within the current vector
    logic [PosWidth-1:0]            pos_reg, pos_next;

    // stage a: sample and its two weights
    logic                           a_valid_reg, a_valid_next;
    logic                           a_last_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_sample_reg;
    coef_t                          a_slope_coef_reg;
    coef_t                          a_offset_coef_reg;

    // stage b: weighted samples
    logic                           b_valid_reg, b_valid_next;
    logic                           b_last_reg;
    logic signed [ProdWidth-1:0]    b_slope_prod_reg;
    logic signed [ProdWidth-1:0]    b_offset_prod_reg;

    // running sums
    acc_t                           slope_acc_reg;
    acc_t                           offset_acc_reg;

    // finished vector sums waiting for rounding
    logic                           r_valid_reg, r_valid_next;
    acc_t                           r_slope_sum_reg;
    acc_t                           r_offset_sum_reg;

    // output register
    logic                           m_valid_reg, m_valid_next;
    out_value_t                     m_slope_reg;
    out_value_t                     m_offset_reg;

    // ------------------------------------------------------------------------
    // flow control: each stage moves when the one after it has room
    // ------------------------------------------------------------------------
    logic out_free;   // output register empty or being drained
    logic r_ready;    // sum stage can take a finished vector
    logic b_fire;     // stage b hands its products to the accumulators
    logic a_fire;     // stage a moves into stage b
    logic s_fire;     // input transfer

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign r_ready       = !r_valid_reg || out_free;
    assign b_fire        = b_valid_reg && (!b_last_reg || r_ready);
    assign a_fire        = a_valid_reg && (!b_valid_reg || b_fire);
    assign s_axis_tready = !a_valid_reg || a_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------------
    acc_t slope_prod_ext;
    acc_t offset_prod_ext;
    acc_t slope_acc_sum;
    acc_t offset_acc_sum;

    // products wrap into the 48-bit accumulators
    assign slope_prod_ext  = ACC_WIDTH'(b_slope_prod_reg);
    assign offset_prod_ext = ACC_WIDTH'(b_offset_prod_reg);
    assign slope_acc_sum   = slope_acc_reg + slope_prod_ext;
    assign offset_acc_sum  = offset_acc_reg + offset_prod_ext;

    // rounding: add half an lsb of the result, arithmetic shift, saturate
    localparam logic signed [ACC_WIDTH:0] RoundBias = (ACC_WIDTH+1)'(1) << SAMPLE_WIDTH;
    localparam logic signed [ACC_WIDTH:0] SatMax    = (ACC_WIDTH+1)'(OUT_MAX);
    localparam logic signed [ACC_WIDTH:0] SatMin    = (ACC_WIDTH+1)'(OUT_MIN);

    logic signed [ACC_WIDTH:0] slope_rnd;
    logic signed [ACC_WIDTH:0] offset_rnd;
    out_value_t                slope_sat;
    out_value_t                offset_sat;

    always_comb begin
        slope_rnd  = ((ACC_WIDTH+1)'(r_slope_sum_reg) + RoundBias) >>> OutShift;
        offset_rnd = ((ACC_WIDTH+1)'(r_offset_sum_reg) + RoundBias) >>> OutShift;
        if (slope_rnd > SatMax) begin
            slope_sat = OUT_WIDTH'(OUT_MAX);
        end else if (slope_rnd < SatMin) begin
            slope_sat = OUT_WIDTH'(OUT_MIN);
        end else begin
            slope_sat = OUT_WIDTH'(slope_rnd);
        end
        if (offset_rnd > SatMax) begin
            offset_sat = OUT_WIDTH'(OUT_MAX);
        end else if (offset_rnd < SatMin) begin
            offset_sat = OUT_WIDTH'(OUT_MIN);
        end else begin
            offset_sat = OUT_WIDTH'(offset_rnd);
        end
    end

    // ------------------------------------------------------------------------
    // next-state logic for control
    // ------------------------------------------------------------------------
    always_comb begin
        pos_next = pos_reg;
        if (s_fire) begin
            pos_next = (pos_reg == LastPos) ? '0 : pos_reg + 1'b1;
        end

        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_fire) begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_fire) begin
            b_valid_next = 1'b1;
        end else if (b_fire) begin
            b_valid_next = 1'b0;
        end

        r_valid_next = r_valid_reg;
        if (b_fire && b_last_reg) begin
            r_valid_next = 1'b1;
        end else if (out_free) begin
            r_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = r_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            r_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            slope_acc_reg  <= '0;
            offset_acc_reg <= '0;
        end else begin
            pos_reg     <= pos_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            r_valid_reg <= r_valid_next;
            m_valid_reg <= m_valid_next;
            // sums clear after the last element of a vector
            if (b_fire) begin
                if (b_last_reg) begin
                    slope_acc_reg  <= '0;
                    offset_acc_reg <= '0;
                end else begin
                    slope_acc_reg  <= slope_acc_sum;
                    offset_acc_reg <= offset_acc_sum;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        // stage a: registered rom read with the sample
        if (s_fire) begin
            a_sample_reg      <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            a_slope_coef_reg  <= slope_rom[pos_reg];
            a_offset_coef_reg <= offset_rom[pos_reg];
            a_last_reg        <= (pos_reg == LastPos);
        end
        // stage b: one multiplier per weight
        if (a_fire) begin
            b_slope_prod_reg  <= a_slope_coef_reg * a_sample_reg;
            b_offset_prod_reg <= a_offset_coef_reg * a_sample_reg;
            b_last_reg        <= a_last_reg;
        end
        // finished vector sums
        if (b_fire && b_last_reg) begin
            r_slope_sum_reg  <= slope_acc_sum;
            r_offset_sum_reg <= offset_acc_sum;
        end
        // rounded, saturated result
        if (out_free && r_valid_reg) begin
            m_slope_reg  <= slope_sat;
            m_offset_reg <= offset_sat;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_offset_reg, m_slope_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `LSLF_ASSERT_NEXT(a_pos_wrap, aclk, aresetn,
        s_fire && pos_reg == LastPos, pos_reg == '0)
    `LSLF_ASSERT_NEXT(a_acc_clear, aclk, aresetn,
        b_fire && b_last_reg, slope_acc_reg == '0 && offset_acc_reg == '0)
    `LSLF_ASSERT_NEXT(a_last_held, aclk, aresetn,
        b_valid_reg && b_last_reg && !r_ready, b_valid_reg && b_last_reg)
    `LSLF_ASSERT_NEXT(a_sum_kept, aclk, aresetn,
        r_valid_reg && !out_free, r_valid_reg && $stable(r_slope_sum_reg))
    `LSLF_ASSERT_SAME(a_no_overrun, aclk, aresetn,
        b_fire && b_last_reg, r_ready)

endmodule

// ----- verif/tb_least_squares_line_fit_top.sv -----
// ----------------------------------------------------------------------------
// least squares line fit testbench
// drives sample vectors through the line fitter and checks every slope and
// offset against a bit-true fit model kept alongside the stream, or against a hand-worked answer where a row gives one
// ----------------------------------------------------------------------------
module tb_least_squares_line_fit_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lslf_pkg::*;

    localparam int VECTOR_LENGTH  = 64;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int TDATA_WIDTH    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_SHIFT      = SAMPLE_WIDTH + 1;
    localparam int RANDOM_VECTORS = 16;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 10;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // how a directed vector is laid out across its elements
    typedef enum logic [2:0] {
        PAT_CONST,
        PAT_STEP,
        PAT_ALT,
        PAT_IMPULSE,
        PAT_RAMP
    } pattern_e;

    // flavours of random vector
    typedef enum logic [1:0] {
        SHAPE_LINE,
        SHAPE_NOISE,
        SHAPE_SMALL,
        SHAPE_RAILS
    } shape_e;

    // result-side stall behaviour
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_EVERY_FOURTH,
        READY_STARVED
    } ready_mode_e;

    typedef struct packed {
        out_value_t slope;
        out_value_t offset;
    } fit_result_t;

    // one directed vector: pattern, its values, and a hand-worked answer
    // where one is obvious
    typedef struct packed {
        pattern_e   pat;
        sample_t    a;
        sample_t    b;
        logic [5:0] pos;
        logic       typed;
        out_value_t slope;
        out_value_t offset;
    } vector_row_t;

    localparam int DIRECTED_ROWS = 11;
    localparam vector_row_t DIRECTED [DIRECTED_ROWS] = '{
        // straight after reset: a silent vector fits a flat zero line
        '{PAT_CONST,   16'sh0000, 16'sh0000, 6'd0,  1'b1, 32'sd0, 32'sd0},
        // rails held for a whole vector
        '{PAT_CONST,   16'sh7fff, 16'sh0000, 6'd0,  1'b0, 32'sd0, 32'sd0},
        '{PAT_CONST,   16'sh8000, 16'sh0000, 6'd0,  1'b0, 32'sd0, 32'sd0},
        // steepest rise and fall the input range allows
        '{PAT_STEP,    16'sh8000, 16'sh7fff, 6'd0,  1'b0, 32'sd0, 32'sd0},
        '{PAT_STEP,    16'sh7fff, 16'sh8000, 6'd0,  1'b0, 32'sd0, 32'sd0},
        // full-scale alternation, every sample bit toggling
        '{PAT_ALT,     16'sh7fff, 16'sh8000, 6'd0,  1'b0, 32'sd0, 32'sd0},
        // lone samples at the first, last and centre positions
        '{PAT_IMPULSE, 16'sh8000, 16'sh0000, 6'd0,  1'b0, 32'sd0, 32'sd0},
        '{PAT_IMPULSE, 16'sh7fff, 16'sh0000, 6'd63, 1'b0, 32'sd0, 32'sd0},
        '{PAT_IMPULSE, 16'sh1000, 16'sh0000, 6'd32, 1'b0, 32'sd0, 32'sd0},
        // exact ramp spanning the full input range
        '{PAT_RAMP,    16'sh0400, 16'sh0000, 6'd0,  1'b0, 32'sd0, 32'sd0},
        // sums must be clear again after the extremes
        '{PAT_CONST,   16'sh0000, 16'sh0000, 6'd0,  1'b1, 32'sd0, 32'sd0}
    };

    // ------------------------------------------------------------------
    // clock, reset and block interface
    // ------------------------------------------------------------------
    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic [TDATA_WIDTH-1:0]       s_axis_tdata  = '0;
    logic                         m_axis_tready = 1'b0;
    logic                         s_axis_tready;
    logic                         m_axis_tvalid;
    logic [2*OUT_WIDTH-1:0]       m_axis_tdata;

    initial begin
        forever #1 aclk = ~aclk;
    end

    least_squares_line_fit_top #(
        .VECTOR_LENGTH(VECTOR_LENGTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),  // fields: sample [15:0]
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)   // fields: slope_value [31:0], offset_value [63:32]
    );

    // ------------------------------------------------------------------
    // line fit model: weight tables, running sums, element index
    // ------------------------------------------------------------------
    coef_t       slope_weight  [VECTOR_LENGTH];
    coef_t       offset_weight [VECTOR_LENGTH];
    acc_t        slope_sum;
    acc_t        offset_sum;
    int          fit_index;
    fit_result_t fit_expected [$];

    int mismatches    = 0;
    int samples_sent  = 0;
    int fits_predicted = 0;
    int fits_checked  = 0;
    int burst_left    = 0;

    // weight to signed Q2.21, nearest with ties away from zero, clipped
    function automatic coef_t quantise_weight(longint num, longint den);
        longint mag;
        longint q;
        longint v;
        mag = (num < 0) ? -num : num;
        q   = ((mag << COEF_FRAC) + den / 2) / den;
        v   = (num < 0) ? -q : q;
        if (v > COEF_MAX) v = COEF_MAX;
        if (v < COEF_MIN) v = COEF_MIN;
        return coef_t'(v);
    endfunction

    // least-squares weights for x = i - N/2, then cleared sums
    function automatic void build_weights();
        longint n;
        longint half;
        longint s1;
        longint s2;
        longint den;
        longint x;
        n    = VECTOR_LENGTH;
        half = n / 2;
        s1   = 0;
        s2   = 0;
        for (int i = 0; i < VECTOR_LENGTH; i++) begin
            x  = i - half;
            s1 += x;
            s2 += x * x;
        end
        den = n * s2 - s1 * s1;
        if (den <= 0) den = 1;
        for (int i = 0; i < VECTOR_LENGTH; i++) begin
            x = i - half;
            slope_weight[i]  = quantise_weight(n * x - s1, den);
            offset_weight[i] = quantise_weight(s2 - s1 * x, den);
        end
        fit_index  = 0;
        slope_sum  = '0;
        offset_sum = '0;
    endfunction

    // drop the fraction bits: nearest with ties upward, then clip to 32 bits
    function automatic out_value_t round_to_output(acc_t a);
        longint v;
        longint q;
        v = longint'(a) + (longint'(1) <<< (OUT_SHIFT - 1));
        q = v >>> OUT_SHIFT;
        if (q > OUT_MAX) q = OUT_MAX;
        if (q < OUT_MIN) q = OUT_MIN;
        return out_value_t'(q);
    endfunction

    // fold one accepted sample into the sums; true when a vector completes
    function automatic bit fit_take_sample(sample_t s, output fit_result_t r);
        longint ps;
        longint po;
        r  = '0;
        ps = longint'(slope_weight[fit_index]) * longint'(s);
        po = longint'(offset_weight[fit_index]) * longint'(s);
        slope_sum  = slope_sum + acc_t'(ps);
        offset_sum = offset_sum + acc_t'(po);
        fit_index++;
        if (fit_index < VECTOR_LENGTH) return 1'b0;
        r.slope    = round_to_output(slope_sum);
        r.offset   = round_to_output(offset_sum);
        slope_sum  = '0;
        offset_sum = '0;
        fit_index  = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic sample_t pattern_sample(vector_row_t row, int i);
        case (row.pat)
            PAT_CONST:   return row.a;
            PAT_STEP:    return (i < VECTOR_LENGTH / 2) ? row.a : row.b;
            PAT_ALT:     return i[0] ? row.b : row.a;
            PAT_IMPULSE: return (i == int'(row.pos)) ? row.a : '0;
            PAT_RAMP:    return sample_t'((i - VECTOR_LENGTH / 2) * int'(row.a));
            default:     return '0;
        endcase
    endfunction

    function automatic sample_t random_sample(shape_e shape, int i, int base, int step);
        int v;
        case (shape)
            SHAPE_LINE: begin
                // noisy straight line, clipped to the input range
                v = base + step * (i - VECTOR_LENGTH / 2) + int'($urandom_range(0, 128)) - 64;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            SHAPE_NOISE: v = int'($urandom_range(0, 65535));
            SHAPE_SMALL: v = int'($urandom_range(0, 511)) - 256;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = -1;
                    default: v = 0;
                endcase
            end
        endcase
        return sample_t'(v);
    endfunction

    // one sample transfer, entered and left at a falling edge; bursts of
    // random length are broken up by random idle gaps on the input side
    task automatic send_sample(input sample_t v, input logic typed, input fit_result_t typed_fit);
        fit_result_t r;
        int          gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= TDATA_WIDTH'($urandom);
                repeat (gap) @(negedge aclk);
            end
            // now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                                     : int'($urandom_range(1, 24));
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_WIDTH'(v);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        // transfer taken at this edge
        burst_left--;
        samples_sent++;
        if (fit_take_sample(v, r)) begin
            // hand-worked answers replace the model's where the row gives one
            fit_expected.push_back(typed ? typed_fit : r);
            fits_predicted++;
        end
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern of its own, changing mode every so often
    // ------------------------------------------------------------------
    ready_mode_e ready_mode  = READY_ALWAYS;
    int          ready_left  = 0;
    int          ready_count = 0;

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = ready_mode_e'($urandom_range(0, 3));
            ready_left = $urandom_range(40, 400);
        end
        ready_left--;
        ready_count++;
        case (ready_mode)
            READY_ALWAYS:       m_axis_tready <= 1'b1;
            READY_COIN:         m_axis_tready <= 1'($urandom_range(0, 1));
            READY_EVERY_FOURTH: m_axis_tready <= (ready_count % 4 == 0);
            default:            m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // result checking against the oldest outstanding fit
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input out_value_t want, input out_value_t got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: fit %0d %s wrong: wanted %0d (%h), got %0d (%h)",
                         $realtime, fits_checked, field, want, want, got, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        fit_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (fit_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result transfer with no fit outstanding: %h",
                             $realtime, m_axis_tdata);
            end else begin
                want = fit_expected.pop_front();
                check_field("slope", want.slope, out_value_t'(m_axis_tdata[OUT_WIDTH-1:0]));
                check_field("offset", want.offset,
                            out_value_t'(m_axis_tdata[2*OUT_WIDTH-1:OUT_WIDTH]));
                fits_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        shape_e shape;
        int     base;
        int     step;

        build_weights();

        // synchronous reset held from the start, released on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed vectors from the table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int i = 0; i < VECTOR_LENGTH; i++)
                send_sample(pattern_sample(DIRECTED[r], i),
                            DIRECTED[r].typed && (i == VECTOR_LENGTH - 1),
                            fit_result_t'{DIRECTED[r].slope, DIRECTED[r].offset});
        end

        // random vectors, mostly noisy lines with the odd harsh one
        for (int n = 0; n < RANDOM_VECTORS; n++) begin
            case ($urandom_range(0, 9))
                0:       shape = SHAPE_NOISE;
                1:       shape = SHAPE_SMALL;
                2:       shape = SHAPE_RAILS;
                default: shape = SHAPE_LINE;
            endcase
            base = int'($urandom_range(0, 40000)) - 20000;
            step = int'($urandom_range(0, 2000)) - 1000;
            for (int i = 0; i < VECTOR_LENGTH; i++)
                send_sample(random_sample(shape, i, base, step), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // let the outstanding fits drain, then keep watching for strays
        while (fit_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d samples in %0d vectors (%0d directed, %0d random)",
                 samples_sent, fits_predicted, DIRECTED_ROWS, RANDOM_VECTORS);
        $display("%0d fits compared, %0d field errors", fits_checked, mismatches);
        if (mismatches == 0) begin
            $display("least_squares_line_fit_top: match");
        end else begin
            $display("least_squares_line_fit_top: mismatch");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("least_squares_line_fit_top: mismatch");
        $finish;
    end

endmodule
